// ===== rtl/ntpg_pkg.sv =====
package ntpg_pkg;

	typedef enum logic [1:0] {
		ACT_TICK = 2'd0,
		ACT_RESP = 2'd1,
		ACT_LOAD = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		MODE_UNIFORM    = 4'd0,
		MODE_COMPLEMENT = 4'd1,
		MODE_REVERSE    = 4'd2,
		MODE_ROTATION   = 4'd3,
		MODE_NEIGHBOR   = 4'd4,
		MODE_SHUFFLE    = 4'd5,
		MODE_TRANSPOSE  = 4'd6,
		MODE_TORNADO    = 4'd7,
		MODE_CUSTOM     = 4'd8
	} mode_t;

	typedef enum logic [2:0] {
		REG_NODE_ID       = 3'd0,
		REG_TRAFFIC_MODE  = 3'd1,
		REG_INJ_THRESHOLD = 3'd2,
		REG_MAX_PACKETS   = 3'd3,
		REG_SOLO_SRC      = 3'd4,
		REG_FIXED_DST     = 3'd5,
		REG_VNET_SEL      = 3'd6,
		REG_RESP_LIMIT    = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_FINISH,
		ST_OUT
	} state_t;

	localparam int CFG_W = 33;

	// draws and table bounds arrive already scaled by 10**PRECISION
	localparam int PRECISION = 3;

	typedef struct packed {
		logic [1:0] code;
		logic [9:0] rand_inject;
		logic [5:0] rand_dest;
		logic [9:0] rand_prob;
		logic [1:0] rand_dir;
		logic [1:0] rand_vnet;
		logic       rand_half;
		logic [3:0] table_index;
		logic [9:0] table_bound;
	} in_item_t;

	typedef struct packed {
		logic       send_valid;
		logic [5:0] destination;
		logic [11:0] address;
		logic [1:0] vnet;
		logic       deadlock;
		logic [31:0] packets_sent;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic start;     // capture item, do tick / response / load bookkeeping
		logic scan_init; // reset table walk
		logic scan_step; // compare current entry, advance
		logic finish;    // form the result beat
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_scan;
		logic scan_done;
	} dp_sts_t;

endpackage

// ===== rtl/ntpg_if.sv =====
interface ntpg_in_if;
	logic                  valid;
	logic                  ready;
	logic [1:0]            action;
	logic [9:0]            rand_inject;
	logic [5:0]            rand_dest;
	logic [9:0]            rand_prob;
	logic [1:0]            rand_dir;
	logic [1:0]            rand_vnet;
	logic                  rand_half;
	logic [3:0]            table_index;
	logic [9:0]            table_bound;
	modport source (output valid, action, rand_inject, rand_dest, rand_prob, rand_dir,
		rand_vnet, rand_half, table_index, table_bound, input ready);
	modport sink (input valid, action, rand_inject, rand_dest, rand_prob, rand_dir,
		rand_vnet, rand_half, table_index, table_bound, output ready);
endinterface

interface ntpg_out_if;
	logic        valid;
	logic        ready;
	logic        send_valid;
	logic [5:0]  destination;
	logic [11:0] address;
	logic [1:0]  vnet;
	logic        deadlock;
	logic [31:0] packets_sent;
	modport source (output valid, send_valid, destination, address, vnet, deadlock,
		packets_sent, input ready);
	modport sink (input valid, send_valid, destination, address, vnet, deadlock,
		packets_sent, output ready);
endinterface

// ===== rtl/ntpg_ram.sv =====
module ntpg_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/ntpg_ctrl.sv =====
module ntpg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              out_fire,
	input  ntpg_pkg::dp_sts_t sts,
	output ntpg_pkg::dp_cmd_t cmd,
	output logic              in_ready,
	output logic              out_valid
);
	ntpg_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ntpg_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ntpg_pkg::ST_IDLE:   if (in_fire) state_d = ntpg_pkg::ST_READ;
			ntpg_pkg::ST_READ:   state_d = sts.need_scan ? ntpg_pkg::ST_SCAN : ntpg_pkg::ST_FINISH;
			ntpg_pkg::ST_SCAN:   if (sts.scan_done) state_d = ntpg_pkg::ST_FINISH;
			ntpg_pkg::ST_FINISH: state_d = ntpg_pkg::ST_OUT;
			ntpg_pkg::ST_OUT:    if (out_fire) state_d = ntpg_pkg::ST_IDLE;
			default:             state_d = ntpg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ntpg_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_fire;
			end
			ntpg_pkg::ST_READ:   cmd.scan_init = 1'b1;
			ntpg_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
			ntpg_pkg::ST_FINISH: cmd.finish = 1'b1;
			ntpg_pkg::ST_OUT:    out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule

// ===== rtl/ntpg_dp.sv =====
module ntpg_dp #(
	parameter int NUM_DESTS    = 64,
	parameter int ROUTER_COUNT = 16,
	parameter int LINE_SHIFT   = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [2:0]                  cfg_index,
	input  logic [ntpg_pkg::CFG_W-1:0]  cfg_data,
	input  ntpg_pkg::in_item_t          item,
	input  ntpg_pkg::dp_cmd_t           cmd,
	output ntpg_pkg::dp_sts_t           sts,
	output ntpg_pkg::out_item_t         res
);
	function automatic int isqrt(input int n);
		int r;
		r = 0;
		while ((r + 1) * (r + 1) <= n) r++;
		return r;
	endfunction

	localparam int RW    = $clog2(ROUTER_COUNT);
	localparam int DW    = (NUM_DESTS > 1) ? $clog2(NUM_DESTS) : 1;
	localparam int RADIX = isqrt(NUM_DESTS);
	localparam int DIRS_RAW = NUM_DESTS / ROUTER_COUNT;
	localparam int DIRS  = (DIRS_RAW == 0) ? 1 : DIRS_RAW;

	// configuration registers
	logic [5:0]  node_id_q;
	logic [3:0]  mode_q;
	logic [9:0]  thr_q;
	logic signed [32:0] maxp_q;
	logic signed [6:0]  ssend_q, sdest_q;
	logic signed [2:0]  vsel_q;
	logic [15:0] rlimit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q <= '0;
			mode_q    <= '0;
			thr_q     <= 10'd100;
			maxp_q    <= -33'sd1;
			ssend_q   <= -7'sd1;
			sdest_q   <= -7'sd1;
			vsel_q    <= -3'sd1;
			rlimit_q  <= 16'd5000;
		end else if (cfg_we) begin
			case (cfg_index)
				ntpg_pkg::REG_NODE_ID:       node_id_q <= cfg_data[5:0];
				ntpg_pkg::REG_TRAFFIC_MODE:  mode_q    <= cfg_data[3:0];
				ntpg_pkg::REG_INJ_THRESHOLD: thr_q     <= cfg_data[9:0];
				ntpg_pkg::REG_MAX_PACKETS:   maxp_q    <= cfg_data[32:0];
				ntpg_pkg::REG_SOLO_SRC:      ssend_q   <= cfg_data[6:0];
				ntpg_pkg::REG_FIXED_DST:     sdest_q   <= cfg_data[6:0];
				ntpg_pkg::REG_VNET_SEL:      vsel_q    <= cfg_data[2:0];
				ntpg_pkg::REG_RESP_LIMIT:    rlimit_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// state
	logic [15:0] idle_q;
	logic [31:0] sent_q;
	logic        dl_q;
	logic        go_q;      // tick passed deadlock/inject/cap/sender tests
	ntpg_pkg::in_item_t it_q;

	logic [15:0] idle_inc;
	logic        hit_limit;
	logic        cap_ok;
	logic        dest_ok;
	assign idle_inc  = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
	assign hit_limit = idle_inc >= rlimit_q;
	assign cap_ok    = maxp_q[32] || ($signed({1'b0, sent_q}) < maxp_q);

	// table walk
	logic [RW:0]  idx_q;
	logic [9:0]   lo_q;
	logic         hit_q;
	logic [RW-1:0] hidx_q;
	logic [9:0]   rdata;
	logic [RW-1:0] raddr;
	logic         rvalid_q;
	logic         tbl_we;

	assign tbl_we = cmd.start && (item.code == ntpg_pkg::ACT_LOAD)
		&& ({28'd0, item.table_index} < ROUTER_COUNT);
	assign raddr  = cmd.scan_step ? idx_q[RW-1:0] + RW'(1) : '0;

	ntpg_ram #(.WIDTH(10), .DEPTH(ROUTER_COUNT)) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (RW'(item.table_index)),
		.wdata (item.table_bound),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= '0;
			sent_q <= '0;
			dl_q   <= 1'b0;
			go_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				go_q <= 1'b0;
				case (item.code)
					ntpg_pkg::ACT_RESP: idle_q <= '0;
					ntpg_pkg::ACT_TICK: begin
						idle_q <= idle_inc;
						if (hit_limit) dl_q <= 1'b1;
						else go_q <= !dl_q && (item.rand_inject < thr_q) && cap_ok
							&& (ssend_q[6] || (node_id_q == ssend_q[5:0]));
					end
					default: ;
				endcase
			end
			if (cmd.finish && go_q && dest_ok && sent_q != 32'hFFFF_FFFF)
				sent_q <= sent_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) it_q <= item;
		if (cmd.scan_init) begin
			idx_q <= '0;
			lo_q  <= '0;
			hit_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (!hit_q && ({{(32-RW-1){1'b0}}, idx_q} != {26'd0, node_id_q})
				&& it_q.rand_prob >= lo_q && it_q.rand_prob < rdata) begin
				hit_q  <= 1'b1;
				hidx_q <= idx_q[RW-1:0];
			end
			lo_q  <= rdata;
			idx_q <= idx_q + (RW+1)'(1);
		end
	end

	assign sts.need_scan = go_q && sdest_q[6] && (mode_q == ntpg_pkg::MODE_CUSTOM);
	assign sts.scan_done = (idx_q == (RW+1)'(ROUTER_COUNT - 1));

	// pattern destination
	logic [31:0] src, sx, sy, d, nb_rev;
	logic [31:0] mult;
	always_comb begin
		src    = {26'd0, node_id_q};
		sx     = src % RADIX;
		sy     = src / RADIX;
		nb_rev = '0;
		for (int i = 0; i < DW; i++) nb_rev[DW-1-i] = src[i];
		mult   = {30'd0, it_q.rand_dir} % DIRS + 32'd1;
		d       = '0;
		dest_ok = 1'b1;
		if (!sdest_q[6]) d = {26'd0, sdest_q[5:0]};
		else begin
			case (mode_q)
				ntpg_pkg::MODE_UNIFORM:    d = {26'd0, it_q.rand_dest} % NUM_DESTS;
				ntpg_pkg::MODE_COMPLEMENT: d = (RADIX - sy - 1) * RADIX + (RADIX - sx - 1);
				ntpg_pkg::MODE_REVERSE:    d = nb_rev;
				ntpg_pkg::MODE_ROTATION:   d = src[0] ? (src >> 1) + NUM_DESTS / 2 : src >> 1;
				ntpg_pkg::MODE_NEIGHBOR:   d = sy * RADIX + (sx + 1) % RADIX;
				ntpg_pkg::MODE_SHUFFLE:
					d = (src < NUM_DESTS / 2) ? src << 1 : (src << 1) - NUM_DESTS + 1;
				ntpg_pkg::MODE_TRANSPOSE:  d = sx * RADIX + sy;
				ntpg_pkg::MODE_TORNADO:    d = sy * RADIX + (sx + RADIX / 2 - 1) % RADIX;
				ntpg_pkg::MODE_CUSTOM: begin
					dest_ok = hit_q;
					d = {{(32-RW){1'b0}}, hidx_q} * mult;
				end
				default: dest_ok = 1'b0;
			endcase
		end
	end

	logic [1:0] vnet;
	always_comb begin
		if (vsel_q == -3'sd1 || vsel_q == 3'sd3)
			vnet = (it_q.rand_vnet == 2'd3) ? 2'd0 : it_q.rand_vnet;
		else if (vsel_q == -3'sd2) vnet = {it_q.rand_half, 1'b0};
		else if (vsel_q[2]) vnet = 2'd2;
		else vnet = vsel_q[1:0];
	end

	logic send;
	logic [31:0] sh;
	assign send = go_q && dest_ok;
	assign sh   = d << LINE_SHIFT;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res.send_valid  <= send;
			res.destination <= send ? d[5:0] : 6'd0;
			res.address     <= send ? sh[11:0] : 12'd0;
			res.vnet        <= send ? vnet : 2'd0;
			res.deadlock    <= dl_q;
			res.packets_sent <= (send && sent_q != 32'hFFFF_FFFF) ? sent_q + 32'd1 : sent_q;
		end
	end
endmodule

// ===== rtl/noc_traffic_pattern_generator.sv =====
// NoC traffic injector for one node.
// Channels: req (sink) takes one item per beat: a tick, a response notice
// or a custom-table load. rsp (source) returns exactly one result beat per
// item: send flag, destination, address, vnet, deadlock flag and count.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle;
// the user must keep to that, as the block itself does not enforce it.
// One item at a time: after acceptance the states READ, FINISH and OUT
// follow, and the result beat is offered in OUT; a custom-mode tick that
// passes with no fixed destination adds SCAN to walk the bound table (one
// table RAM read per cycle). The next item is taken in the cycle after the
// result beat leaves. Reset (arst_n low) restores the register defaults,
// clears the idle counter, packet count and deadlock flag. The bound table
// is not cleared and must be loaded before custom mode reads it.
// When the receiver holds rsp.ready low the result beat waits in its
// register and no new item is accepted.
module noc_traffic_pattern_generator #(
	parameter int NUM_DESTS    = 64,
	parameter int ROUTER_COUNT = 16,
	parameter int LINE_SHIFT   = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [ntpg_pkg::CFG_W-1:0] cfg_data,
	ntpg_in_if.sink                    req,
	ntpg_out_if.source                 rsp
);
	ntpg_pkg::dp_cmd_t   cmd;
	ntpg_pkg::dp_sts_t   sts;
	ntpg_pkg::in_item_t  item;
	ntpg_pkg::out_item_t res;
	logic in_fire, out_fire;

	assign in_fire  = req.valid && req.ready;
	assign out_fire = rsp.valid && rsp.ready;

	always_comb begin
		item.code        = req.action;
		item.rand_inject = req.rand_inject;
		item.rand_dest   = req.rand_dest;
		item.rand_prob   = req.rand_prob;
		item.rand_dir    = req.rand_dir;
		item.rand_vnet   = req.rand_vnet;
		item.rand_half   = req.rand_half;
		item.table_index = req.table_index;
		item.table_bound = req.table_bound;
	end

	ntpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.out_fire  (out_fire),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (req.ready),
		.out_valid (rsp.valid)
	);

	ntpg_dp #(
		.NUM_DESTS(NUM_DESTS), .ROUTER_COUNT(ROUTER_COUNT),
		.LINE_SHIFT(LINE_SHIFT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res)
	);

	assign rsp.send_valid   = res.send_valid;
	assign rsp.destination  = res.destination;
	assign rsp.address      = res.address;
	assign rsp.vnet         = res.vnet;
	assign rsp.deadlock     = res.deadlock;
	assign rsp.packets_sent = res.packets_sent;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid)) else $error("input taken while result pending");
	a_empty_nosend: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.send_valid |-> rsp.destination == 6'd0 && rsp.vnet == 2'd0)
		else $error("fields set without a packet");
	a_dl_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.deadlock |-> !rsp.send_valid) else $error("sent in deadlock");
endmodule
